FILE: sv/kf3_pkg.sv
// Shared types, register indexes, bank layout and helper functions for the Kalman core.
package kf3_pkg;

	typedef struct packed {
		logic signed [31:0] measurement;
		logic signed [31:0] accel_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] filtered;
		logic signed [31:0] est_first;
		logic signed [31:0] est_second;
		logic signed [31:0] est_third;
		logic               sat_flag;
	} out_t;

	typedef struct packed {
		logic [47:0] f_row0;
		logic [47:0] f_row1;
		logic [47:0] f_row2;
		logic [47:0] c_vec;
		logic [47:0] q1_row0;
		logic [47:0] q1_row1;
		logic [47:0] q1_row2;
		logic [30:0] q2;
	} cfg_t;

	localparam logic [3:0] REG_F_ROW0  = 4'd0;
	localparam logic [3:0] REG_F_ROW1  = 4'd1;
	localparam logic [3:0] REG_F_ROW2  = 4'd2;
	localparam logic [3:0] REG_C_VEC   = 4'd3;
	localparam logic [3:0] REG_Q1_ROW0 = 4'd4;
	localparam logic [3:0] REG_Q1_ROW1 = 4'd5;
	localparam logic [3:0] REG_Q1_ROW2 = 4'd6;
	localparam logic [3:0] REG_Q2      = 4'd7;

	// Working bank layout: covariance, F*P scratch, state, P*C' (later C*P), gain, prediction.
	localparam int          BANK_DEPTH = 30;
	localparam logic [4:0]  P_BASE  = 5'd0;
	localparam logic [4:0]  FP_BASE = 5'd9;
	localparam logic [4:0]  X_BASE  = 5'd18;
	localparam logic [4:0]  KC_BASE = 5'd21;
	localparam logic [4:0]  G_BASE  = 5'd24;
	localparam logic [4:0]  XP_BASE = 5'd27;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MAC,
		OP_WRM,
		OP_LATCH,
		OP_MUL,
		OP_MULA,
		OP_UPD,
		OP_ADDA,
		OP_DIVST,
		OP_DIVRUN,
		OP_DIVWR,
		OP_OUT
	} op_e;

	typedef enum logic [1:0] {
		M_PLAIN,
		M_Q2,
		M_D,
		M_Q1
	} mode_e;

	typedef enum logic [1:0] {
		MAT_F,
		MAT_C,
		MAT_Q
	} mat_e;

	typedef struct packed {
		op_e        op;
		logic [4:0] ra;
		logic [4:0] wa;
		mat_e       mat;
		logic [1:0] row;
		logic [1:0] col;
		logic       clr;
		mode_e      mode;
		logic       to_filt;
		logic       sub;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [49:0] v);
		sat_t s;
		if (v > 50'sd2147483647) begin
			s.ovf = 1'b1;
			s.val = 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			s.ovf = 1'b1;
			s.val = 32'sh80000000;
		end else begin
			s.ovf = 1'b0;
			s.val = v[31:0];
		end
		return s;
	endfunction

	function automatic logic signed [15:0] coef16(input cfg_t c, input mat_e m,
			input logic [1:0] row, input logic [1:0] col);
		logic [47:0] r;
		logic [15:0] e;
		case (m)
			MAT_F: begin
				case (row)
					2'd0:    r = c.f_row0;
					2'd1:    r = c.f_row1;
					default: r = c.f_row2;
				endcase
			end
			MAT_Q: begin
				case (row)
					2'd0:    r = c.q1_row0;
					2'd1:    r = c.q1_row1;
					default: r = c.q1_row2;
				endcase
			end
			default: r = c.c_vec;
		endcase
		case (col)
			2'd0:    e = r[15:0];
			2'd1:    e = r[31:16];
			2'd2:    e = r[47:32];
			default: e = 16'd0;
		endcase
		return $signed(e);
	endfunction

	function automatic logic [4:0] addr3(input logic [4:0] base, input logic [1:0] row,
			input logic [1:0] col);
		return base + {2'b00, row, 1'b0} + {3'b000, row} + {3'b000, col};
	endfunction

endpackage

FILE: sv/kalman_filter_three_state_core.sv
// Top level of the three-state scalar-measurement Kalman filter core.
// One item (measurement, acceleration) is taken at a time; it yields one result with the
// filtered measurement, the corrected state and a saturation flag. The update runs on one
// shared 32x16 multiply-accumulate unit (one product per cycle), one 32x32 multiplier for
// the gain terms, and a restoring divider that produces one quotient bit per cycle for
// each of the three gain entries. A new item is accepted as soon as the previous one has
// been handed to the output register, while that result still waits.
// Configuration writes are registered and must only happen while the core is idle.
module kalman_filter_three_state_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kf3_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output kf3_pkg::out_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [3:0]     cfg_index,
	input  logic [47:0]    cfg_data
);
	import kf3_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	kf3_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kf3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	kf3_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg      (cfg),
		.status   (status),
		.out_data (out_data)
	);

endmodule

FILE: sv/kf3_regs.sv
// Configuration register file for the Kalman core.
module kf3_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_index,
	input  logic [47:0]          cfg_data,
	output kf3_pkg::cfg_t        cfg
);
	import kf3_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.f_row0  <= 48'd4096;
			cfg_q.f_row1  <= 48'd268435456;
			cfg_q.f_row2  <= 48'd17592186044416;
			cfg_q.c_vec   <= 48'd4096;
			cfg_q.q1_row0 <= '0;
			cfg_q.q1_row1 <= '0;
			cfg_q.q1_row2 <= '0;
			cfg_q.q2      <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_F_ROW0:  cfg_q.f_row0  <= cfg_data;
				REG_F_ROW1:  cfg_q.f_row1  <= cfg_data;
				REG_F_ROW2:  cfg_q.f_row2  <= cfg_data;
				REG_C_VEC:   cfg_q.c_vec   <= cfg_data;
				REG_Q1_ROW0: cfg_q.q1_row0 <= cfg_data;
				REG_Q1_ROW1: cfg_q.q1_row1 <= cfg_data;
				REG_Q1_ROW2: cfg_q.q1_row2 <= cfg_data;
				REG_Q2:      cfg_q.q2      <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/kf3_datapath.sv
// Datapath: working bank, multiply-accumulate, gain multiplier and serial divider.
module kf3_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  kf3_pkg::cmd_t    cmd,
	input  kf3_pkg::in_t     in_data,
	input  kf3_pkg::cfg_t    cfg,
	output kf3_pkg::status_t status,
	output kf3_pkg::out_t    out_data
);
	import kf3_pkg::*;

	logic signed [31:0] bank_q [BANK_DEPTH];
	logic signed [51:0] acc_q;
	logic signed [31:0] gl_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] d_q;
	logic signed [31:0] a_q;
	logic signed [31:0] r_q;
	logic               rzero_q;
	logic signed [31:0] alpha_q;
	logic signed [31:0] filt_q;
	logic               flag_q;
	logic [47:0]        div_n_q;
	logic [31:0]        div_r_q;
	logic [31:0]        div_d_q;
	logic               div_neg_q;
	logic [5:0]         div_cnt_q;
	out_t               out_q;

	logic signed [31:0] rd;
	logic signed [15:0] cf;
	logic signed [47:0] mac_prod;
	logic signed [51:0] acc_h;
	logic signed [39:0] t12;
	logic signed [63:0] prod_h;
	logic signed [47:0] r16;
	logic [31:0]        abs_rd;
	logic [31:0]        abs_r;
	logic [32:0]        rem_sh;
	logic               rem_ge;
	logic [32:0]        rem_new;
	sat_t               s1, sq2, sd, sq1, su, sa;
	logic               wr_en;
	logic signed [31:0] wr_val;
	logic               ovf;

	assign rd       = bank_q[cmd.ra];
	assign cf       = coef16(cfg, cmd.mat, cmd.row, cmd.col);
	assign mac_prod = rd * cf;
	assign acc_h    = acc_q + 52'sd2048;
	assign t12      = acc_h[51:12];
	assign prod_h   = prod_q + 64'sd32768;
	assign r16      = prod_h[63:16];
	assign abs_rd   = rd[31] ? (~rd + 32'd1) : rd;
	assign abs_r    = r_q[31] ? (~r_q + 32'd1) : r_q;
	assign rem_sh   = {div_r_q, div_n_q[47]};
	assign rem_ge   = rem_sh >= {1'b0, div_d_q};
	assign rem_new  = rem_ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;

	assign s1  = sat32(50'(t12));
	assign sq2 = sat32(50'(t12) + 50'($signed({1'b0, cfg.q2})));
	assign sd  = sat32(50'(d_q) - 50'(s1.val));
	assign sq1 = sat32(50'(s1.val) + 50'($signed({cf, 4'b0000})));
	assign su  = sat32(cmd.sub ? (50'(rd) - 50'(r16)) : (50'(rd) + 50'(r16)));
	assign sa  = sat32(50'(rd) + 50'(a_q));

	assign status.div_last = div_cnt_q == 6'd47;
	assign out_data        = out_q;

	always_comb begin
		wr_en  = 1'b0;
		wr_val = s1.val;
		ovf    = 1'b0;
		case (cmd.op)
			OP_WRM: begin
				case (cmd.mode)
					M_PLAIN: begin
						wr_en = !cmd.to_filt;
						ovf   = s1.ovf;
					end
					M_Q2: ovf = sq2.ovf || (sq2.val == 32'sd0);
					M_D:  ovf = s1.ovf || sd.ovf;
					M_Q1: begin
						wr_en  = 1'b1;
						wr_val = sq1.val;
						ovf    = s1.ovf || sq1.ovf;
					end
					default: ;
				endcase
			end
			OP_UPD: begin
				wr_en  = 1'b1;
				wr_val = su.val;
				ovf    = su.ovf;
			end
			OP_ADDA: begin
				wr_en  = 1'b1;
				wr_val = sa.val;
				ovf    = sa.ovf;
			end
			OP_DIVWR: begin
				wr_en = 1'b1;
				if (rzero_q) begin
					wr_val = 32'sd0;
				end else if (!div_neg_q) begin
					ovf    = div_n_q > 48'd2147483647;
					wr_val = ovf ? 32'sh7fffffff : div_n_q[31:0];
				end else begin
					ovf    = div_n_q > 48'd2147483648;
					wr_val = ovf ? 32'sh80000000 : (~div_n_q[31:0] + 32'd1);
				end
			end
			default: ;
		endcase
	end

	// State, flags and divider count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < BANK_DEPTH; n++) begin
				bank_q[n] <= '0;
			end
			flag_q    <= 1'b0;
			rzero_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (wr_en) begin
				bank_q[cmd.wa] <= wr_val;
			end
			if (cmd.op == OP_LOAD) begin
				flag_q <= 1'b0;
			end else if (ovf) begin
				flag_q <= 1'b1;
			end
			if (cmd.op == OP_WRM && cmd.mode == M_Q2) begin
				rzero_q <= sq2.val == 32'sd0;
			end
			if (cmd.op == OP_DIVST) begin
				div_cnt_q <= '0;
			end else if (cmd.op == OP_DIVRUN) begin
				div_cnt_q <= div_cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d_q <= in_data.measurement;
				a_q <= in_data.accel_in;
			end
			OP_MAC: acc_q <= (cmd.clr ? 52'sd0 : acc_q) + 52'(mac_prod);
			OP_WRM: begin
				if (cmd.mode == M_Q2) begin
					r_q <= sq2.val;
				end
				if (cmd.mode == M_D) begin
					alpha_q <= sd.val;
				end
				if (cmd.mode == M_PLAIN && cmd.to_filt) begin
					filt_q <= s1.val;
				end
			end
			OP_LATCH: gl_q <= rd;
			OP_MUL:   prod_q <= gl_q * rd;
			OP_MULA:  prod_q <= gl_q * alpha_q;
			OP_DIVST: begin
				div_n_q   <= {abs_rd, 16'd0} + {17'd0, abs_r[31:1]};
				div_r_q   <= '0;
				div_d_q   <= abs_r;
				div_neg_q <= rd[31] ^ r_q[31];
			end
			OP_DIVRUN: begin
				// shift one dividend bit into the remainder, one quotient bit into div_n_q
				div_r_q <= rem_new[31:0];
				div_n_q <= {div_n_q[46:0], rem_ge};
			end
			OP_OUT: begin
				out_q.filtered   <= filt_q;
				out_q.est_first  <= bank_q[X_BASE];
				out_q.est_second <= bank_q[X_BASE + 5'd1];
				out_q.est_third  <= bank_q[X_BASE + 5'd2];
				out_q.sat_flag   <= flag_q;
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/kf3_ctrl.sv
// Controller: sequences the filter update over the datapath, one item at a time.
module kf3_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  kf3_pkg::status_t status,
	output kf3_pkg::cmd_t    cmd
);
	import kf3_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_KC,
		PH_R,
		PH_DIV,
		PH_ACC,
		PH_XP,
		PH_ALPHA,
		PH_X,
		PH_FILT,
		PH_CK,
		PH_P,
		PH_FP,
		PH_COV,
		PH_OUT
	} ph_t;

	ph_t        ph_q;
	logic [1:0] i_q, j_q, k_q;
	logic       out_valid_q;

	logic [1:0] k_last;
	logic       hold;
	logic       loop_i;
	logic       loop_j;
	logic       out_load;
	ph_t        ph_next;

	assign in_stall  = ph_q != PH_IDLE;
	assign out_valid = out_valid_q;
	assign out_load  = !out_valid_q || !out_stall;

	always_comb begin
		k_last  = 2'd3;
		hold    = 1'b0;
		loop_i  = 1'b0;
		loop_j  = 1'b0;
		ph_next = PH_OUT;
		case (ph_q)
			PH_KC:    begin loop_i = 1'b1; ph_next = PH_R; end
			PH_R:     ph_next = PH_DIV;
			PH_DIV: begin
				k_last  = 2'd2;
				loop_i  = 1'b1;
				hold    = (k_q == 2'd1) && !status.div_last;
				ph_next = PH_ACC;
			end
			PH_ACC:   begin k_last = 2'd0; ph_next = PH_XP; end
			PH_XP:    begin loop_i = 1'b1; ph_next = PH_ALPHA; end
			PH_ALPHA: ph_next = PH_X;
			PH_X:     begin k_last = 2'd2; loop_i = 1'b1; ph_next = PH_FILT; end
			PH_FILT:  ph_next = PH_CK;
			PH_CK:    begin loop_i = 1'b1; ph_next = PH_P; end
			PH_P: begin
				k_last  = 2'd2;
				loop_i  = 1'b1;
				loop_j  = 1'b1;
				ph_next = PH_FP;
			end
			PH_FP:    begin loop_i = 1'b1; loop_j = 1'b1; ph_next = PH_COV; end
			PH_COV:   begin loop_i = 1'b1; loop_j = 1'b1; ph_next = PH_OUT; end
			default: ;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_NOP;
		cmd.mat     = MAT_C;
		cmd.mode    = M_PLAIN;
		cmd.col     = k_q;
		cmd.clr     = k_q == 2'd0;
		case (ph_q)
			PH_IDLE: if (in_valid) cmd.op = OP_LOAD;
			PH_KC: begin
				cmd.op = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra = addr3(P_BASE, i_q, k_q);
				cmd.wa = KC_BASE + {3'b000, i_q};
			end
			PH_R: begin
				cmd.op   = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra   = KC_BASE + {3'b000, k_q};
				cmd.mode = M_Q2;
			end
			PH_DIV: begin
				case (k_q)
					2'd0:    cmd.op = OP_DIVST;
					2'd1:    cmd.op = OP_DIVRUN;
					default: cmd.op = OP_DIVWR;
				endcase
				cmd.ra = KC_BASE + {3'b000, i_q};
				cmd.wa = G_BASE + {3'b000, i_q};
			end
			PH_ACC: begin
				cmd.op = OP_ADDA;
				cmd.ra = X_BASE + 5'd2;
				cmd.wa = X_BASE + 5'd2;
			end
			PH_XP: begin
				cmd.op  = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra  = X_BASE + {3'b000, k_q};
				cmd.mat = MAT_F;
				cmd.row = i_q;
				cmd.wa  = XP_BASE + {3'b000, i_q};
			end
			PH_ALPHA: begin
				cmd.op   = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra   = XP_BASE + {3'b000, k_q};
				cmd.mode = M_D;
			end
			PH_X: begin
				case (k_q)
					2'd0:    cmd.op = OP_LATCH;
					2'd1:    cmd.op = OP_MULA;
					default: cmd.op = OP_UPD;
				endcase
				cmd.ra = (k_q == 2'd0) ? (G_BASE + {3'b000, i_q}) : (XP_BASE + {3'b000, i_q});
				cmd.wa = X_BASE + {3'b000, i_q};
			end
			PH_FILT: begin
				cmd.op      = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra      = X_BASE + {3'b000, k_q};
				cmd.to_filt = 1'b1;
			end
			PH_CK: begin
				// C*P lands in the P*C' slots, which are spent by now
				cmd.op = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra = addr3(P_BASE, k_q, i_q);
				cmd.wa = KC_BASE + {3'b000, i_q};
			end
			PH_P: begin
				case (k_q)
					2'd0: begin
						cmd.op = OP_LATCH;
						cmd.ra = G_BASE + {3'b000, i_q};
					end
					2'd1: begin
						cmd.op = OP_MUL;
						cmd.ra = KC_BASE + {3'b000, j_q};
					end
					default: begin
						cmd.op = OP_UPD;
						cmd.ra = addr3(P_BASE, i_q, j_q);
					end
				endcase
				cmd.wa  = addr3(P_BASE, i_q, j_q);
				cmd.sub = 1'b1;
			end
			PH_FP: begin
				cmd.op  = (k_q == 2'd3) ? OP_WRM : OP_MAC;
				cmd.ra  = addr3(P_BASE, k_q, j_q);
				cmd.mat = MAT_F;
				cmd.row = i_q;
				cmd.wa  = addr3(FP_BASE, i_q, j_q);
			end
			PH_COV: begin
				if (k_q == 2'd3) begin
					cmd.op   = OP_WRM;
					cmd.mode = M_Q1;
					cmd.mat  = MAT_Q;
					cmd.row  = i_q;
					cmd.col  = j_q;
				end else begin
					cmd.op  = OP_MAC;
					cmd.mat = MAT_F;
					cmd.row = j_q;
				end
				cmd.ra = addr3(FP_BASE, i_q, k_q);
				cmd.wa = addr3(P_BASE, i_q, j_q);
			end
			PH_OUT: if (out_load) cmd.op = OP_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ph_q == PH_OUT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ph_q)
				PH_IDLE: begin
					if (in_valid) begin
						ph_q <= PH_KC;
						i_q  <= '0;
						j_q  <= '0;
						k_q  <= '0;
					end
				end
				PH_OUT: begin
					if (out_load) begin
						ph_q <= PH_IDLE;
					end
				end
				default: begin
					if (hold) begin
						k_q <= k_q;
					end else if (k_q != k_last) begin
						k_q <= k_q + 2'd1;
					end else begin
						k_q <= '0;
						if (loop_j && j_q != 2'd2) begin
							j_q <= j_q + 2'd1;
						end else begin
							j_q <= '0;
							if (loop_i && i_q != 2'd2) begin
								i_q <= i_q + 2'd1;
							end else begin
								i_q  <= '0;
								ph_q <= ph_next;
							end
						end
					end
				end
			endcase
		end
	end

endmodule
